FILE: rtl/eqh_pkg.sv
// shared types, constants and elaboration-time constant functions
package eqh_pkg;

   localparam int DEF_ANGLE_BITS    = 32;
   localparam int DEF_CORDIC_STAGES = 30;
   localparam int VEC_FRAC          = 30;
   localparam int VEC_W             = 35;
   localparam int SQRT_STEPS        = 31;
   localparam int SQRT_W            = 62;
   localparam int GMST_LAT          = 4;
   localparam int MUL_LAT           = 5;
   localparam logic [23:0] JD2_EPOCH = 24'd4903091;

   typedef struct packed {
      logic [21:0]        julian_day_number;
      logic [16:0]        seconds_of_day;
      logic [31:0]        right_ascension;
      logic signed [31:0] declination;
   } req_type;

   typedef struct packed {
      logic signed [31:0] altitude;
      logic [31:0]        azimuth;
   } rsp_type;

   typedef enum logic {
      REG_LATITUDE  = 1'b0,
      REG_LONGITUDE = 1'b1
   } csr_reg_type;

   function automatic logic [127:0] udivmod(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return {q, r[63:0]};
   endfunction

   function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
      logic [127:0] qr;
      qr = udivmod(n, d);
      return qr[127:64];
   endfunction

   function automatic logic [63:0] divfix(input logic [63:0] num, input logic [63:0] den,
                                          input int bits);
      logic [127:0] qr;
      logic [63:0]  r;
      logic [63:0]  q;
      qr = udivmod(num, den);
      r  = qr[63:0];
      q  = '0;
      for (int i = 0; i < 96; i++) begin
         if (i < bits) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
               r    = r - den;
               q[0] = 1'b1;
            end
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] n);
      logic [63:0] nn;
      logic [63:0] r;
      logic [63:0] b;
      nn = n;
      r  = '0;
      b  = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (b > nn) b = b >> 2;
      end
      for (int k = 0; k < 32; k++) begin
         if (b != 64'd0) begin
            if (nn >= r + b) begin
               nn = nn - (r + b);
               r  = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // atan(1/n) in q62 by the arctangent series
   function automatic logic [63:0] atan_recip(input logic [63:0] n);
      logic [63:0] p;
      logic [63:0] acc;
      logic [63:0] t;
      logic [63:0] nn;
      p   = udiv(64'd1 << 62, n);
      nn  = n * n;
      acc = '0;
      for (int k = 0; k < 64; k++) begin
         if (p != 64'd0) begin
            t = udiv(p, 64'(2 * k + 1));
            if (k[0]) acc = acc - t;
            else acc = acc + t;
            p = udiv(p, nn);
         end
      end
      return acc;
   endfunction

   // atan(2^-i) in q62, i at least one
   function automatic logic [63:0] atan_pow2(input int i);
      logic [63:0] acc;
      logic [63:0] t;
      logic        done;
      int          e;
      acc  = '0;
      done = 1'b0;
      for (int k = 0; k < 32; k++) begin
         e = i * (2 * k + 1);
         if (e > 62) done = 1'b1;
         if (!done) begin
            t = udiv(64'd1 << (62 - e), 64'(2 * k + 1));
            if (k[0]) acc = acc - t;
            else acc = acc + t;
         end
      end
      return acc;
   endfunction

   // arctangent table entry as a binary angle of ab bits
   function automatic logic [63:0] atan_tab(input int i, input int ab);
      logic [63:0] qpi;
      logic [63:0] t64;
      qpi = 4 * atan_recip(64'd5) - atan_recip(64'd239);
      if (i == 0) t64 = 64'd1 << 61;
      else t64 = divfix(atan_pow2(i), qpi, 61);
      return (t64 + (64'd1 << (63 - ab))) >> (64 - ab);
   endfunction

   // reciprocal of the cordic gain in q30
   function automatic logic [63:0] cordic_kinv(input int stages);
      logic [63:0] p;
      logic [63:0] root;
      p = 64'd1 << 60;
      for (int i = 0; i < 64; i++) begin
         if (i < stages && 2 * i < 64) p = p + (p >> (2 * i));
      end
      root = isqrt64(p);
      return udiv((64'd1 << 60) + (root >> 1), root);
   endfunction

   localparam logic [63:0] K2_DEN = 64'd27 * 64'd1220703125 * 64'd237169;
   localparam logic [63:0] GMST_C0 = divfix(64'd6697374558, 64'd24000000000, 64);
   localparam logic [63:0] GMST_K1 = divfix(64'd2400051336, 64'd1753200000000, 64);
   localparam logic [63:0] GMST_K2 = divfix(64'd12931, K2_DEN, 83);
   localparam logic [63:0] GMST_K3 = divfix(64'd10027379093, 64'd864000000000000, 64);

endpackage

FILE: rtl/eqh_gmst.sv
// sidereal time front end: hour angle as a 64-bit fraction of a turn
module eqh_gmst (
   input  logic        clock,
   input  logic        en,
   input  logic [21:0] jdn,
   input  logic [16:0] sec,
   input  logic [31:0] ra,
   input  logic [31:0] dec,
   input  logic [31:0] lon,
   output logic [63:0] hour_turn,
   output logic [31:0] dec_o
);
   import eqh_pkg::*;

   localparam logic signed [32:0] K1L = {1'b0, GMST_K1[31:0]};
   localparam logic signed [32:0] K1H = {1'b0, GMST_K1[63:32]};
   localparam logic [47:0]        K2  = GMST_K2[47:0];
   localparam logic [49:0]        K3  = GMST_K3[49:0];

   logic signed [23:0] e_ff, e_in;
   logic [16:0]        sec_ff;
   logic [31:0]        ra1_ff, ra2_ff, ra3_ff;
   logic [31:0]        dec1_ff, dec2_ff, dec3_ff, dec4_ff;
   logic signed [56:0] p1l_ff, p1l_in;
   logic signed [56:0] p1h_full;
   logic [31:0]        p1h_ff;
   logic signed [47:0] ee_full;
   logic [47:0]        ee_ff;
   logic [66:0]        p3_full;
   logic [63:0]        p3_ff;
   logic [63:0]        a_ff, a_in;
   logic [71:0]        ql_ff, qh_ff;
   logic [95:0]        q_sum;
   logic [63:0]        g_ff, g_in;

   assign e_in     = signed'({1'b0, jdn, 1'b0}) - signed'(JD2_EPOCH);
   assign p1l_in   = K1L * e_ff;
   assign p1h_full = K1H * e_ff;
   assign ee_full  = e_ff * e_ff;
   assign p3_full  = K3 * sec_ff;
   assign a_in     = GMST_C0 + ({{7{p1l_ff[56]}}, p1l_ff} + {p1h_ff, 32'd0}) + p3_ff;
   assign q_sum    = {qh_ff, 24'd0} + {24'd0, ql_ff};
   assign g_in     = a_ff + q_sum[95:32] + {lon - ra3_ff, 32'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff    <= e_in;
         sec_ff  <= sec;
         ra1_ff  <= ra;
         dec1_ff <= dec;
         p1l_ff  <= p1l_in;
         p1h_ff  <= p1h_full[31:0];
         ee_ff   <= ee_full[47:0];
         p3_ff   <= p3_full[63:0];
         ra2_ff  <= ra1_ff;
         dec2_ff <= dec1_ff;
         a_ff    <= a_in;
         ql_ff   <= ee_ff[23:0] * K2;
         qh_ff   <= ee_ff[47:24] * K2;
         ra3_ff  <= ra2_ff;
         dec3_ff <= dec2_ff;
         g_ff    <= g_in;
         dec4_ff <= dec3_ff;
      end
   end

   assign hour_turn = g_ff;
   assign dec_o     = dec4_ff;

endmodule

FILE: rtl/eqh_rot_cell.sv
// one cordic rotation-mode micro-rotation with its stage registers
module eqh_rot_cell #(
   parameter int AB    = eqh_pkg::DEF_ANGLE_BITS,
   parameter int STAGE = 0
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [eqh_pkg::VEC_W-1:0] x_i,
   input  logic signed [eqh_pkg::VEC_W-1:0] y_i,
   input  logic signed [AB+1:0]           z_i,
   input  logic                           f_i,
   output logic signed [eqh_pkg::VEC_W-1:0] x_o,
   output logic signed [eqh_pkg::VEC_W-1:0] y_o,
   output logic signed [AB+1:0]           z_o,
   output logic                           f_o
);
   import eqh_pkg::*;

   localparam int ZW = AB + 2;
   localparam logic [63:0] TAB64 = atan_tab(STAGE, AB);
   localparam logic signed [ZW-1:0] TAB = TAB64[ZW-1:0];

   logic signed [VEC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]    z_ff, z_in;
   logic                    f_ff;

   always_comb begin
      if (z_i >= 0) begin
         x_in = x_i - (y_i >>> STAGE);
         y_in = y_i + (x_i >>> STAGE);
         z_in = z_i - TAB;
      end else begin
         x_in = x_i + (y_i >>> STAGE);
         y_in = y_i - (x_i >>> STAGE);
         z_in = z_i + TAB;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         f_ff <= f_i;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;
   assign f_o = f_ff;

endmodule

FILE: rtl/eqh_vec_cell.sv
// one cordic vectoring-mode micro-rotation with its stage registers
module eqh_vec_cell #(
   parameter int AB    = eqh_pkg::DEF_ANGLE_BITS,
   parameter int STAGE = 0
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [eqh_pkg::VEC_W-1:0] x_i,
   input  logic signed [eqh_pkg::VEC_W-1:0] y_i,
   input  logic signed [AB+1:0]           z_i,
   input  logic                           f_i,
   output logic signed [eqh_pkg::VEC_W-1:0] x_o,
   output logic signed [eqh_pkg::VEC_W-1:0] y_o,
   output logic signed [AB+1:0]           z_o,
   output logic                           f_o
);
   import eqh_pkg::*;

   localparam int ZW = AB + 2;
   localparam logic [63:0] TAB64 = atan_tab(STAGE, AB);
   localparam logic signed [ZW-1:0] TAB = TAB64[ZW-1:0];

   logic signed [VEC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]    z_ff, z_in;
   logic                    f_ff;

   always_comb begin
      if (y_i >= 0) begin
         x_in = x_i + (y_i >>> STAGE);
         y_in = y_i - (x_i >>> STAGE);
         z_in = z_i + TAB;
      end else begin
         x_in = x_i - (y_i >>> STAGE);
         y_in = y_i + (x_i >>> STAGE);
         z_in = z_i - TAB;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         f_ff <= f_i;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;
   assign f_o = f_ff;

endmodule

FILE: rtl/eqh_sqrt_cell.sv
// one digit of the restoring integer square root, carrying side data along
module eqh_sqrt_cell #(
   parameter int K  = 0,
   parameter int PW = 1
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [eqh_pkg::SQRT_W-1:0]    n_i,
   input  logic [eqh_pkg::SQRT_W-1:0]    r_i,
   input  logic [PW-1:0]                 p_i,
   output logic [eqh_pkg::SQRT_W-1:0]    n_o,
   output logic [eqh_pkg::SQRT_W-1:0]    r_o,
   output logic [PW-1:0]                 p_o
);
   import eqh_pkg::*;

   localparam logic [SQRT_W-1:0] BIT = {{(SQRT_W-1){1'b0}}, 1'b1} << (2 * K);

   logic [SQRT_W-1:0] n_ff, n_in, r_ff, r_in, trial;
   logic [PW-1:0]     p_ff;

   assign trial = r_i + BIT;

   always_comb begin
      if (n_i >= trial) begin
         n_in = n_i - trial;
         r_in = (r_i >> 1) + BIT;
      end else begin
         n_in = n_i;
         r_in = r_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff <= n_in;
         r_ff <= r_in;
         p_ff <= p_i;
      end
   end

   assign n_o = n_ff;
   assign r_o = r_ff;
   assign p_o = p_ff;

endmodule

FILE: rtl/equatorial_to_horizontal_coords.sv
// equatorial to horizontal conversion: top level, csr block and pipeline glue
// pipeline from an accepted req beat to rsp_valid, in order:
//   (4 sidereal-time stages, the rotation cells, 5 product stages,
//   31 square-root cells, the vectoring cells, then the output register)
// throughput: one beat per cycle while the output drains; all rows of cells stall together
// reset: clears the pipeline valid bits, the output valid bit and both csrs
module equatorial_to_horizontal_coords #(
   parameter int ANGLE_BITS    = eqh_pkg::DEF_ANGLE_BITS,
   parameter int CORDIC_STAGES = eqh_pkg::DEF_CORDIC_STAGES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  eqh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output eqh_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import eqh_pkg::*;

   localparam int AB  = ANGLE_BITS;
   localparam int N   = CORDIC_STAGES;
   localparam int ZW  = AB + 2;
   localparam int VW  = VEC_W;
   localparam int PW  = 3 * VW;
   localparam int L   = GMST_LAT + N + MUL_LAT + SQRT_STEPS + N;
   localparam int SQ_END = GMST_LAT + N + MUL_LAT + SQRT_STEPS - 1;
   localparam logic [63:0] KINV64 = cordic_kinv(N);
   localparam logic signed [VW-1:0] KINV = KINV64[VW-1:0];
   localparam logic signed [VW-1:0] ONE  = VW'(1) << VEC_FRAC;
   localparam logic signed [VW:0]   ONE_X = (VW+1)'(1) << VEC_FRAC;
   localparam logic signed [ZW-1:0] QTR  = ZW'(1) << (AB - 2);
   localparam logic signed [ZW-1:0] HALF = ZW'(1) << (AB - 1);
   localparam logic [SQRT_W-1:0]    ONE_SQ = SQRT_W'(1) << (2 * VEC_FRAC);

   // fold the angle into the right half plane, remember the flip
   function automatic logic [ZW:0] rot_pre(input logic [AB-1:0] a);
      logic signed [ZW-1:0] z;
      logic                 f;
      z = ZW'(signed'(a));
      f = 1'b0;
      if (z > QTR) begin
         z = z - HALF;
         f = 1'b1;
      end else if (z < -QTR) begin
         z = z + HALF;
         f = 1'b1;
      end
      return {f, z};
   endfunction

   // q30 product, floor rounding
   function automatic logic signed [VW-1:0] mulq(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b);
      logic signed [2*VW-1:0] p;
      p = a * b;
      return p[VEC_FRAC +: VW];
   endfunction

   // ---------------- csr block
   logic [31:0] lat_ff, lat_in, lon_ff, lon_in;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_comb begin
      lat_in = lat_ff;
      lon_in = lon_ff;
      if (csr_wr) begin
         unique case (csr_reg_type'(paddr[2]))
            REG_LATITUDE:  lat_in = pwdata;
            REG_LONGITUDE: lon_in = pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg_type'(paddr[2]))
         REG_LATITUDE:  prdata = lat_ff;
         REG_LONGITUDE: prdata = lon_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff <= '0;
         lon_ff <= '0;
      end else begin
         lat_ff <= lat_in;
         lon_ff <= lon_in;
      end
   end

   // ---------------- flow control
   // the whole row of cells moves together; it only halts when the last
   // stage holds a result and the output register cannot take it
   logic [L-1:0] vld_ff, vld_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;
   logic         rsp_load;
   logic         pipe_en;

   assign rsp_load     = ~rsp_valid_ff | rsp_ready;
   assign pipe_en      = ~vld_ff[L-1] | rsp_load;
   assign req_ready    = pipe_en;
   assign vld_in       = pipe_en ? {vld_ff[L-2:0], req_valid} : vld_ff;
   assign rsp_valid_in = rsp_load ? vld_ff[L-1] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- sidereal time and hour angle
   logic [63:0] hour_turn;
   logic [31:0] dec_raw;

   eqh_gmst u_gmst (
      .clock     (clock),
      .en        (pipe_en),
      .jdn       (req_data.julian_day_number),
      .sec       (req_data.seconds_of_day),
      .ra        (req_data.right_ascension),
      .dec       (req_data.declination),
      .lon       (lon_ff),
      .hour_turn (hour_turn),
      .dec_o     (dec_raw)
   );

   // 32-bit angles rescaled to the working angle width
   logic [63:0]   lat_wide, dec_wide;
   logic [ZW:0]   h_pre, l_pre, d_pre;
   assign lat_wide = {lat_ff, 32'd0};
   assign dec_wide = {dec_raw, 32'd0};
   assign h_pre    = rot_pre(hour_turn[63 -: AB]);
   assign l_pre    = rot_pre(lat_wide[63 -: AB]);
   assign d_pre    = rot_pre(dec_wide[63 -: AB]);

   // ---------------- three rows of rotation cells: hour angle, latitude, declination
   logic signed [VW-1:0] hx [N+1], hy [N+1], lx [N+1], ly [N+1], dx [N+1], dy [N+1];
   logic signed [ZW-1:0] hz [N+1], lz [N+1], dz [N+1];
   logic                 hf [N+1], lf [N+1], df [N+1];

   assign hx[0] = KINV;
   assign hy[0] = '0;
   assign hz[0] = h_pre[ZW-1:0];
   assign hf[0] = h_pre[ZW];
   assign lx[0] = KINV;
   assign ly[0] = '0;
   assign lz[0] = l_pre[ZW-1:0];
   assign lf[0] = l_pre[ZW];
   assign dx[0] = KINV;
   assign dy[0] = '0;
   assign dz[0] = d_pre[ZW-1:0];
   assign df[0] = d_pre[ZW];

   for (genvar i = 0; i < N; i++) begin : g_rot
      eqh_rot_cell #(.AB(AB), .STAGE(i)) u_h (
         .clock(clock), .en(pipe_en),
         .x_i(hx[i]), .y_i(hy[i]), .z_i(hz[i]), .f_i(hf[i]),
         .x_o(hx[i+1]), .y_o(hy[i+1]), .z_o(hz[i+1]), .f_o(hf[i+1])
      );
      eqh_rot_cell #(.AB(AB), .STAGE(i)) u_l (
         .clock(clock), .en(pipe_en),
         .x_i(lx[i]), .y_i(ly[i]), .z_i(lz[i]), .f_i(lf[i]),
         .x_o(lx[i+1]), .y_o(ly[i+1]), .z_o(lz[i+1]), .f_o(lf[i+1])
      );
      eqh_rot_cell #(.AB(AB), .STAGE(i)) u_d (
         .clock(clock), .en(pipe_en),
         .x_i(dx[i]), .y_i(dy[i]), .z_i(dz[i]), .f_i(df[i]),
         .x_o(dx[i+1]), .y_o(dy[i+1]), .z_o(dz[i+1]), .f_o(df[i+1])
      );
   end

   // ---------------- undo the half-turn flip, then the spherical products
   logic signed [VW-1:0] ch_ff, sh_ff, cl_ff, sl_ff, cd_ff, sd_ff;
   logic signed [VW-1:0] cdch_ff, slsd_ff, cdsh_ff, sdcl_ff, cl1_ff, sl1_ff;
   logic signed [VW-1:0] t_ff, u_ff, slsd2_ff, cdsh2_ff, sdcl2_ff;
   logic signed [VW-1:0] s_ff, s_in, ax_ff, ay_ff;
   logic signed [VW:0]   s_sum;
   logic signed [VW-1:0] s4_ff, ax4_ff, ay4_ff;
   logic signed [2*VW-1:0] ss_full;
   logic [SQRT_W-1:0]    n4_ff;

   assign s_sum   = {slsd2_ff[VW-1], slsd2_ff} + {t_ff[VW-1], t_ff};
   assign ss_full = s_ff * s_ff;

   // sine of altitude clamped to the unit interval
   always_comb begin
      if (s_sum > ONE_X) s_in = ONE;
      else if (s_sum < -ONE_X) s_in = -ONE;
      else s_in = s_sum[VW-1:0];
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ch_ff    <= hf[N] ? -hx[N] : hx[N];
         sh_ff    <= hf[N] ? -hy[N] : hy[N];
         cl_ff    <= lf[N] ? -lx[N] : lx[N];
         sl_ff    <= lf[N] ? -ly[N] : ly[N];
         cd_ff    <= df[N] ? -dx[N] : dx[N];
         sd_ff    <= df[N] ? -dy[N] : dy[N];
         cdch_ff  <= mulq(cd_ff, ch_ff);
         slsd_ff  <= mulq(sl_ff, sd_ff);
         cdsh_ff  <= mulq(cd_ff, sh_ff);
         sdcl_ff  <= mulq(sd_ff, cl_ff);
         cl1_ff   <= cl_ff;
         sl1_ff   <= sl_ff;
         t_ff     <= mulq(cl1_ff, cdch_ff);
         u_ff     <= mulq(cdch_ff, sl1_ff);
         slsd2_ff <= slsd_ff;
         cdsh2_ff <= cdsh_ff;
         sdcl2_ff <= sdcl_ff;
         s_ff     <= s_in;
         ax_ff    <= u_ff - sdcl2_ff;
         ay_ff    <= cdsh2_ff;
         s4_ff    <= s_ff;
         ax4_ff   <= ax_ff;
         ay4_ff   <= ay_ff;
         n4_ff    <= ONE_SQ - ss_full[SQRT_W-1:0];
      end
   end

   // ---------------- square root row: cosine of altitude
   logic [SQRT_W-1:0] sq_n [SQRT_STEPS+1];
   logic [SQRT_W-1:0] sq_r [SQRT_STEPS+1];
   logic [PW-1:0]     sq_p [SQRT_STEPS+1];

   assign sq_n[0] = n4_ff;
   assign sq_r[0] = '0;
   assign sq_p[0] = {s4_ff, ax4_ff, ay4_ff};

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      eqh_sqrt_cell #(.K(SQRT_STEPS - 1 - j), .PW(PW)) u_sq (
         .clock(clock), .en(pipe_en),
         .n_i(sq_n[j]), .r_i(sq_r[j]), .p_i(sq_p[j]),
         .n_o(sq_n[j+1]), .r_o(sq_r[j+1]), .p_o(sq_p[j+1])
      );
   end

   // ---------------- two rows of vectoring cells: altitude and azimuth
   logic signed [VW-1:0] alt_x0, alt_y0, az_x0, az_y0;
   logic signed [VW-1:0] ax [N+1], ay [N+1], zx [N+1], zy [N+1];
   logic signed [ZW-1:0] az [N+1], zz [N+1];
   logic                 af [N+1], zf [N+1];

   assign alt_x0 = sq_r[SQRT_STEPS][VW-1:0];
   assign alt_y0 = sq_p[SQRT_STEPS][PW-1 -: VW];
   assign az_x0  = sq_p[SQRT_STEPS][2*VW-1 -: VW];
   assign az_y0  = sq_p[SQRT_STEPS][VW-1:0];

   // left half plane: mirror and start from half a turn; the flag marks
   // the undefined direction of a zero vector
   always_comb begin
      af[0] = (alt_x0 == 0) && (alt_y0 == 0);
      if (alt_x0 < 0) begin
         ax[0] = -alt_x0;
         ay[0] = -alt_y0;
         az[0] = HALF;
      end else begin
         ax[0] = alt_x0;
         ay[0] = alt_y0;
         az[0] = '0;
      end
      zf[0] = (az_x0 == 0) && (az_y0 == 0);
      if (az_x0 < 0) begin
         zx[0] = -az_x0;
         zy[0] = -az_y0;
         zz[0] = HALF;
      end else begin
         zx[0] = az_x0;
         zy[0] = az_y0;
         zz[0] = '0;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_vec
      eqh_vec_cell #(.AB(AB), .STAGE(i)) u_alt (
         .clock(clock), .en(pipe_en),
         .x_i(ax[i]), .y_i(ay[i]), .z_i(az[i]), .f_i(af[i]),
         .x_o(ax[i+1]), .y_o(ay[i+1]), .z_o(az[i+1]), .f_o(af[i+1])
      );
      eqh_vec_cell #(.AB(AB), .STAGE(i)) u_az (
         .clock(clock), .en(pipe_en),
         .x_i(zx[i]), .y_i(zy[i]), .z_i(zz[i]), .f_i(zf[i]),
         .x_o(zx[i+1]), .y_o(zy[i+1]), .z_o(zz[i+1]), .f_o(zf[i+1])
      );
   end

   // ---------------- back to 32-bit angles and into the output register
   logic [AB-1:0]    alt_ab, az_ab;
   logic [AB+31:0]   alt_wide, az_wide;

   assign alt_ab   = af[N] ? '0 : az[N][AB-1:0];
   assign az_ab    = zf[N] ? '0 : zz[N][AB-1:0];
   assign alt_wide = {alt_ab, 32'd0};
   assign az_wide  = {az_ab, 32'd0};

   assign rsp_data_in.altitude = signed'(alt_wide[AB+31 -: 32]);
   assign rsp_data_in.azimuth  = az_wide[AB+31 -: 32];

   always_ff @(posedge clock) begin
      if (rsp_load && vld_ff[L-1]) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input blocked with an empty output register");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && vld_ff[L-1]) |-> !req_ready)
      else $error("input taken while the last stage cannot drain");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted beat did not enter the pipeline");

   a_sqrt_remainder: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SQ_END] |-> (sq_n[SQRT_STEPS] <= (sq_r[SQRT_STEPS] << 1)))
      else $error("square root remainder out of range");

endmodule
